FILE: hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and helpers of the linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Widths of the fields on the ports.
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RVAL_W  = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 48;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;
  localparam int unsigned      HASH_SHIFT     = 3;

  typedef enum logic [0:0] {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  // Bounds a requested table size to 1..slots.
  function automatic int unsigned live_count(logic [CFG_W-1:0] req, int unsigned slots);
    int unsigned r;
    r = int'(req);
    if (r == 0) begin
      r = 1;
    end else if (r > slots) begin
      r = slots;
    end
    return r;
  endfunction

endpackage

FILE: hdl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Multi-cycle remainder unit: dividend mod divisor, four dividend bits a cycle.
// ----------------------------------------------------------------------------
module lpht_mod #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int unsigned DIGIT     = 4;
  localparam int unsigned DIV_STEPS = (DIVIDEND_W + DIGIT - 1) / DIGIT;
  localparam int unsigned PAD_W     = DIV_STEPS * DIGIT;
  localparam int unsigned STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic                 busy;
  logic [STEP_W-1:0]    cnt;
  logic [PAD_W-1:0]     quo;
  logic [DIVISOR_W-1:0] div;
  logic [DIVISOR_W-1:0] rem_next;

  // Restoring remainder steps; the partial remainder stays below the divisor.
  always_comb begin
    logic [DIVISOR_W:0]   t;
    logic [DIVISOR_W-1:0] r;
    r = remainder;
    for (int b = 0; b < DIGIT; b++) begin
      t = {r, quo[PAD_W-1-b]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = DIVISOR_W'(t);
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= PAD_W'(dividend);
      div       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo       <= {quo[PAD_W-DIGIT-1:0], DIGIT'(0)};
      remainder <= rem_next;
    end
  end

endmodule

FILE: hdl/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store
// Key and value memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpht_store #(
  parameter int unsigned SLOTS      = 1024,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [KEY_BITS-1:0]      wr_key,
  input  logic [VALUE_BITS-1:0]    wr_value,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [KEY_BITS-1:0]      rd_key,
  output logic [VALUE_BITS-1:0]    rd_value
);

  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
    end
  end

endmodule

FILE: hdl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value hash table with linear probing, get and put.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | tuser[0] func; tdata key[31:0], value[63:32]
//  m_*     | out       | tuser[1:0] status; tdata read_value[31:0], slot[41:32]
//  cfg_*   | in        | cfg_data = table_size, written when cfg_we is high
//
// A request passes an accept step, the remainder unit (its DIV_STEPS is
// ceil(KEY_BITS/4), 8 by default), a memory read, one probe per slot and a
// final step that posts the result. A zero key goes from the accept step
// straight to the posting step. The memory read port, one slot per cycle,
// sets the probe rate. After reset a clearing pass writes every key entry to
// zero, during which s_tready stays low. The result sits in an output
// register, so the next request is taken while m_tvalid waits on m_tready.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
  #(
  parameter int unsigned SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lpht_pkg::CFG_W-1:0]    cfg_data,   // table_size
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lpht_pkg::S_DATA_W-1:0] s_tdata,    // key[31:0], value[63:32]
  input  logic [0:0]                    s_tuser,    // func[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpht_pkg::M_DATA_W-1:0] m_tdata,    // read_value[31:0], slot[41:32], zeros
  output logic [1:0]                    m_tuser     // status[1:0]
);

  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_HASH   = 5'b00100,
    S_PROBE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]      n_live;
  logic [IDX_W-1:0]      clr_idx;
  logic                  op_put;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]      home;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      probes;
  logic [RVAL_W-1:0]     res_value;
  status_t               res_status;
  logic [IDX_W-1:0]      res_slot;
  logic                  res_write;

  logic [RVAL_W-1:0]     out_value;
  status_t               out_status;
  logic [SLOT_W-1:0]     out_slot;

  logic [KEY_BITS-1:0]   key_in;
  logic [KEY_BITS-1:0]   hash_sum;
  logic                  accept;
  logic                  out_free;
  logic                  post;
  logic                  div_done;
  logic [CNT_W-1:0]      div_rem;
  logic [IDX_W-1:0]      idx_nxt;
  logic                  slot_empty;
  logic                  slot_match;
  logic                  probe_end;
  logic                  probe_full;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  // Handshake and hash of the incoming key; the sum wraps at KEY_BITS.
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign key_in   = KEY_BITS'(s_tdata[KEY_W-1:0]);
  assign hash_sum = key_in + (key_in >> HASH_SHIFT);
  assign out_free = !m_tvalid || m_tready;
  assign post     = (state == S_FINISH) && out_free;

  lpht_mod #(
    .DIVIDEND_W (KEY_BITS),
    .DIVISOR_W  (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (key_in != '0)),
    .dividend  (hash_sum),
    .divisor   (n_live),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Probe step: the next slot wraps to zero at the live table size.
  assign idx_nxt    = ((CNT_W'(idx) + 1'b1) == n_live) ? '0 : idx + 1'b1;
  assign slot_empty = (rd_key == '0);
  assign slot_match = (rd_key == key_r);
  assign probe_end  = slot_empty || slot_match;
  assign probe_full = !probe_end && ((probes + 1'b1) == n_live);

  // Reads come from the hash state (home slot) and the probe state (next
  // slot). Writes come from the clearing pass and from a put being posted.
  // The two never fall in the same cycle, so no forwarding is needed.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_nxt;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_key  = key_r;
    if (state == S_HASH && div_done) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(div_rem);
    end else if (state == S_PROBE && !probe_end && !probe_full) begin
      rd_en = 1'b1;
    end
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_key  = '0;
    end else if (post && res_write) begin
      wr_en = 1'b1;
    end
  end

  lpht_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (val_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (key_in == '0) ? S_FINISH : S_HASH;
        end
      end
      S_HASH: begin
        if (div_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_end || probe_full) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      n_live   <= CNT_W'(live_count(TABLE_SIZE_RST, SLOTS));
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_we) begin
        n_live <= CNT_W'(live_count(cfg_data, SLOTS));
      end
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request, probe and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_put     <= (s_tuser[0] == FUNC_PUT);
      key_r      <= key_in;
      val_r      <= VALUE_BITS'(s_tdata[KEY_W +: VALUE_W]);
      res_value  <= '0;
      res_status <= ST_ZERO;
      res_slot   <= '0;
      res_write  <= 1'b0;
    end
    if (state == S_HASH && div_done) begin
      home   <= IDX_W'(div_rem);
      idx    <= IDX_W'(div_rem);
      probes <= '0;
    end
    if (state == S_PROBE) begin
      if (probe_end) begin
        res_slot <= idx;
        if (op_put) begin
          res_status <= ST_OK;
          res_write  <= 1'b1;
        end else if (slot_match) begin
          res_status <= ST_OK;
          res_value  <= RVAL_W'(rd_value);
        end else begin
          res_status <= ST_MISS;
        end
      end else if (probe_full) begin
        res_slot   <= home;
        res_status <= ST_FULL;
      end else begin
        idx    <= idx_nxt;
        probes <= probes + 1'b1;
      end
    end
    if (post) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_slot   <= SLOT_W'(res_slot);
    end
  end

  assign m_tdata = {(M_DATA_W - RVAL_W - SLOT_W)'(0), out_slot, out_value};
  assign m_tuser = out_status;

  // No request is taken and no result appears while the keys are cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!s_tready && !m_tvalid))
    else $error("request or result during the clearing pass");

  // The remainder unit only finishes while the control waits on it.
  a_div_done_hash: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_HASH))
    else $error("remainder unit finished outside the hash state");

  // Memory writes come from the clearing pass or a posted put only.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_CLEAR) || (post && op_put && res_status == ST_OK)))
    else $error("unexpected memory write");

  // A rejected zero key reports an all-zero data word.
  a_zero_key_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_ZERO) |-> (m_tdata == '0))
    else $error("zero key result carries data");

endmodule
